FILE: sv/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg: shared types and constants of the RGB 3x3 convolution filter
// Register map, pixel and column types, result beat layout, default sizes.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int COEF_BITS_DEF  = 16;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int IMG_W_W      = 11;
  localparam int IMG_H_W      = 13;
  localparam int KROW_W       = 48;
  localparam int COEF_FIELD_W = 16;

  localparam int OUT_X_W     = 10;
  localparam int OUT_Y_W     = 12;
  localparam int OFIFO_DEPTH = 8;

  localparam logic [IMG_W_W-1:0] IMG_W_RST  = 11'd1024;
  localparam logic [IMG_H_W-1:0] IMG_H_RST  = 13'd1024;
  localparam logic [KROW_W-1:0]  KTOP_RST   = 48'h0;
  localparam logic [KROW_W-1:0]  KMID_RST   = 48'h10000;
  localparam logic [KROW_W-1:0]  KBOT_RST   = 48'h0;

  localparam int PIX_MAX = 255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_t;

  // channel 0 red, 1 green, 2 blue
  typedef logic [2:0][7:0] rgb_t;
  // row 0 top, 1 middle, 2 bottom
  typedef rgb_t [2:0] col_t;

  typedef struct packed {
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    rgb_t               pix;
    logic               border;
    logic               last;
  } out_beat_t;

endpackage

FILE: sv/rgbc_ram.sv
// ----------------------------------------------------------------------------
// rgbc_ram: generic single-write, single-read RAM
// Registered read port; a read at the address being written returns old data.
// ----------------------------------------------------------------------------
module rgbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rgbc_cell.sv
// ----------------------------------------------------------------------------
// rgbc_cell: one column cell of the 3x3 window
// Holds one window column, hands it to the left neighbor on each pixel beat
// and registers the column's weighted sum for each channel.
// ----------------------------------------------------------------------------
module rgbc_cell
  import rgbc_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int PW        = COEF_BITS + 10
) (
  input  logic                        clk,
  input  logic                        shift_i,
  input  col_t                        col_i,
  input  logic signed [COEF_BITS-1:0] coef_i [3],
  output col_t                        col_o,
  output logic signed [PW-1:0]        part_o [3]
);

  col_t               col_r;
  logic signed [PW-1:0] part_r   [3];
  logic signed [PW-1:0] part_nxt [3];

  always_comb begin
    logic signed [PW-1:0] p0, p1, p2;
    for (int ch = 0; ch < 3; ch++) begin
      p0 = coef_i[0] * $signed({1'b0, col_r[0][ch]});
      p1 = coef_i[1] * $signed({1'b0, col_r[1][ch]});
      p2 = coef_i[2] * $signed({1'b0, col_r[2][ch]});
      part_nxt[ch] = p0 + p1 + p2;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_i) begin
      col_r <= col_i;
    end
    part_r <= part_nxt;
  end

  assign col_o  = col_r;
  assign part_o = part_r;

endmodule

FILE: sv/rgbc_ofifo.sv
// ----------------------------------------------------------------------------
// rgbc_ofifo: result queue
// Takes up to two beats per cycle, hands out one beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rgbc_ofifo
  import rgbc_pkg::*;
#(
  parameter int DEPTH = OFIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push0_i,
  input  out_beat_t data0_i,
  input  logic      push1_i,
  input  out_beat_t data1_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_beat_t         mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push0_i) + AW'(push1_i);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    count_nxt  = count_r + CW'(push0_i) + CW'(push1_i) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0_i) begin
      mem[wr_ptr_r] <= data0_i;
    end
    if (push1_i) begin
      mem[wr_ptr_r + AW'(1)] <= data1_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/rgb_conv3x3_clamp.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp: streaming 3x3 convolution of RGB pixels with clamping
// Path of a pixel: line store read and stage 1 registers, window cells, stage 3 sum and clamp, result queue.
// Throughput: one pixel per cycle while in_ready is high; a pixel that yields two
// results takes the single result port twice, behind an 8-entry queue.
// Reset (synchronous, rst_n low): position to (0,0), registers to defaults,
// queue empty. Line stores are not cleared.
// ----------------------------------------------------------------------------
module rgb_conv3x3_clamp
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_frame_start,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_X_W-1:0]    out_x,
  output logic [OUT_Y_W-1:0]    out_y,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_is_border,
  output logic                  out_last_of_item
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = COEF_BITS + 10;
  localparam int SW = COEF_BITS + 12;
  localparam int RW = $clog2(OFIFO_DEPTH + 1);

  // configuration
  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [KROW_W-1:0]  ktop_r, kmid_r, kbot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RST;
      img_h_r <= IMG_H_RST;
      ktop_r  <= KTOP_RST;
      kmid_r  <= KMID_RST;
      kbot_r  <= KBOT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   img_w_r <= cfg_wdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata[IMG_H_W-1:0];
        REG_KERNEL_TOP:    ktop_r  <= cfg_wdata[KROW_W-1:0];
        REG_KERNEL_MIDDLE: kmid_r  <= cfg_wdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kbot_r  <= cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;

  always_comb begin
    if (img_w_r < 3) begin
      w_sat = WW'(3);
    end else if (img_w_r > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(img_w_r);
    end
    if (img_h_r < 3) begin
      h_sat = HW'(3);
    end else if (img_h_r > MAX_HEIGHT) begin
      h_sat = HW'(MAX_HEIGHT);
    end else begin
      h_sat = HW'(img_h_r);
    end
  end

  // coefficients: [row] per column cell
  logic signed [COEF_BITS-1:0] coef_l [3];
  logic signed [COEF_BITS-1:0] coef_c [3];
  logic signed [COEF_BITS-1:0] coef_r [3];

  always_comb begin
    coef_l[0] = ktop_r[0 +: COEF_BITS];
    coef_l[1] = kmid_r[0 +: COEF_BITS];
    coef_l[2] = kbot_r[0 +: COEF_BITS];
    coef_c[0] = ktop_r[COEF_FIELD_W +: COEF_BITS];
    coef_c[1] = kmid_r[COEF_FIELD_W +: COEF_BITS];
    coef_c[2] = kbot_r[COEF_FIELD_W +: COEF_BITS];
    coef_r[0] = ktop_r[2*COEF_FIELD_W +: COEF_BITS];
    coef_r[1] = kmid_r[2*COEF_FIELD_W +: COEF_BITS];
    coef_r[2] = kbot_r[2*COEF_FIELD_W +: COEF_BITS];
  end

  // position tracking at accept
  logic          in_fire, pop;
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [XW-1:0] x_cur;
  logic [YW-1:0] y_cur;
  logic          has_f, has_b;
  rgb_t          px;

  assign px = {in_blue, in_green, in_red};

  always_comb begin
    logic [WW-1:0] c0, xn;
    logic [HW-1:0] r0, rn;
    c0 = in_frame_start ? '0 : WW'(col_r);
    r0 = in_frame_start ? '0 : HW'(row_r);
    if (c0 >= w_sat) begin
      c0 = '0;
      r0 = r0 + HW'(1);
    end
    if (r0 >= h_sat) begin
      r0 = '0;
    end
    x_cur = XW'(c0);
    y_cur = YW'(r0);
    has_f = (c0 >= WW'(2)) && (r0 >= HW'(2));
    has_b = (c0 == '0) || (r0 == '0) || (c0 == w_sat - WW'(1)) ||
            (r0 == h_sat - HW'(1));
    xn = c0 + WW'(1);
    rn = r0 + HW'(1);
    if (xn >= w_sat) begin
      col_nxt = '0;
      row_nxt = (rn >= h_sat) ? '0 : YW'(rn);
    end else begin
      col_nxt = XW'(xn);
      row_nxt = y_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // result slot reservation
  logic [RW-1:0] res_r, res_nxt;

  assign in_ready = (res_r <= RW'(OFIFO_DEPTH - 2));
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    res_nxt = res_r - RW'(pop);
    if (in_fire) begin
      res_nxt = res_nxt + RW'(has_f) + RW'(has_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  // stage 1: line store read data, window shift, line store write
  logic          s1_valid_r, s2_valid_r, s3_valid_r;
  logic [XW-1:0] s1_x_r, s2_x_r, s3_x_r;
  logic [YW-1:0] s1_y_r, s2_y_r, s3_y_r;
  rgb_t          s1_px_r, s2_px_r, s3_px_r;
  logic          s1_f_r, s2_f_r, s3_f_r;
  logic          s1_b_r, s2_b_r, s3_b_r;

  rgb_t upper_q, lower_q, upper_eff, lower_eff;
  logic fwd_hit_r;
  rgb_t fwd_upper_r, fwd_lower_r;

  rgbc_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (lower_eff),
    .re    (in_fire),
    .raddr (x_cur),
    .rdata (upper_q)
  );

  rgbc_ram #(.WIDTH($bits(rgb_t)), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_x_r),
    .wdata (s1_px_r),
    .re    (in_fire),
    .raddr (x_cur),
    .rdata (lower_q)
  );

  // same column written on the edge it was read: take the written values
  assign upper_eff = fwd_hit_r ? fwd_upper_r : upper_q;
  assign lower_eff = fwd_hit_r ? fwd_lower_r : lower_q;

  always_ff @(posedge clk) begin
    fwd_upper_r <= lower_eff;
    fwd_lower_r <= s1_px_r;
    s1_x_r  <= x_cur;
    s1_y_r  <= y_cur;
    s1_px_r <= px;
    s1_f_r  <= has_f;
    s1_b_r  <= has_b;
    s2_x_r  <= s1_x_r;
    s2_y_r  <= s1_y_r;
    s2_px_r <= s1_px_r;
    s2_f_r  <= s1_f_r;
    s2_b_r  <= s1_b_r;
    s3_x_r  <= s2_x_r;
    s3_y_r  <= s2_y_r;
    s3_px_r <= s2_px_r;
    s3_f_r  <= s2_f_r;
    s3_b_r  <= s2_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      fwd_hit_r  <= in_fire && s1_valid_r && (s1_x_r == x_cur);
      s1_valid_r <= in_fire;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // window: chain of column cells, right cell takes the new column
  col_t                 new_col, col_rc, col_cc;
  logic signed [PW-1:0] part_l [3];
  logic signed [PW-1:0] part_c [3];
  logic signed [PW-1:0] part_r [3];

  assign new_col = {s1_px_r, lower_eff, upper_eff};

  rgbc_cell #(.COEF_BITS(COEF_BITS), .PW(PW)) u_cell_r (
    .clk     (clk),
    .shift_i (s1_valid_r),
    .col_i   (new_col),
    .coef_i  (coef_r),
    .col_o   (col_rc),
    .part_o  (part_r)
  );

  rgbc_cell #(.COEF_BITS(COEF_BITS), .PW(PW)) u_cell_c (
    .clk     (clk),
    .shift_i (s1_valid_r),
    .col_i   (col_rc),
    .coef_i  (coef_c),
    .col_o   (col_cc),
    .part_o  (part_c)
  );

  rgbc_cell #(.COEF_BITS(COEF_BITS), .PW(PW)) u_cell_l (
    .clk     (clk),
    .shift_i (s1_valid_r),
    .col_i   (col_cc),
    .coef_i  (coef_l),
    .col_o   (),
    .part_o  (part_l)
  );

  // stage 3: column sum and clamp
  rgb_t filt;

  always_comb begin
    logic signed [SW-1:0] sum;
    for (int ch = 0; ch < 3; ch++) begin
      sum = SW'(part_l[ch]) + SW'(part_c[ch]) + SW'(part_r[ch]);
      if (sum < 0) begin
        filt[ch] = 8'd0;
      end else if (sum > PIX_MAX) begin
        filt[ch] = 8'(PIX_MAX);
      end else begin
        filt[ch] = sum[7:0];
      end
    end
  end

  out_beat_t beat_f, beat_b, q_data0, q_data1, q_out;
  logic      q_push0, q_push1;

  always_comb begin
    beat_f.x      = OUT_X_W'(s3_x_r - XW'(1));
    beat_f.y      = OUT_Y_W'(s3_y_r - YW'(1));
    beat_f.pix    = filt;
    beat_f.border = 1'b0;
    beat_f.last   = !s3_b_r;
    beat_b.x      = OUT_X_W'(s3_x_r);
    beat_b.y      = OUT_Y_W'(s3_y_r);
    beat_b.pix    = s3_px_r;
    beat_b.border = 1'b1;
    beat_b.last   = 1'b1;
    q_push0 = s3_valid_r && (s3_f_r || s3_b_r);
    q_push1 = s3_valid_r && s3_f_r && s3_b_r;
    q_data0 = s3_f_r ? beat_f : beat_b;
    q_data1 = beat_b;
  end

  rgbc_ofifo #(.DEPTH(OFIFO_DEPTH)) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0_i   (q_push0),
    .data0_i   (q_data0),
    .push1_i   (q_push1),
    .data1_i   (q_data1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_out)
  );

  assign out_x            = q_out.x;
  assign out_y            = q_out.y;
  assign out_red          = q_out.pix[0];
  assign out_green        = q_out.pix[1];
  assign out_blue         = q_out.pix[2];
  assign out_is_border    = q_out.border;
  assign out_last_of_item = q_out.last;

endmodule
